>>> sv/gbr_pkg.sv
// Shared types, register codes and helper functions of the GPIO bank register block.
`default_nettype none

package gbr_pkg;

    // Operation codes.
    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // Register regions.
    localparam logic [1:0] RGN_FASTIO = 2'd0;
    localparam logic [1:0] RGN_CTRL   = 2'd1;
    localparam logic [1:0] RGN_PADS   = 2'd2;
    localparam logic [1:0] RGN_IRQEN  = 2'd3;

    // Fast io words.
    localparam logic [1:0] WSEL_OUT = 2'd0;
    localparam logic [1:0] WSEL_OE  = 2'd1;
    localparam logic [1:0] WSEL_IN  = 2'd2;

    // Write kinds.
    localparam logic [1:0] ALIAS_PLAIN = 2'd0;
    localparam logic [1:0] ALIAS_XOR   = 2'd1;
    localparam logic [1:0] ALIAS_SET   = 2'd2;
    localparam logic [1:0] ALIAS_CLR   = 2'd3;

    // Override codes.
    localparam logic [1:0] OVR_PASS = 2'd0;
    localparam logic [1:0] OVR_INV  = 2'd1;
    localparam logic [1:0] OVR_LOW  = 2'd2;
    localparam logic [1:0] OVR_HIGH = 2'd3;

    // Pin control word layout.
    localparam logic [4:0] FSEL_GPIO    = 5'd5;
    localparam logic [4:0] FSEL_NULL    = 5'd31;
    localparam int         CTL_OOV_LSB  = 12;
    localparam int         CTL_EOV_LSB  = 14;
    localparam int         CTL_IOV_LSB  = 16;
    localparam int         CTL_MSK_LSB  = 20;
    localparam int         CTL_IRQRESET = 28;

    // One pin's entry in the control memory: pad word above control word.
    localparam int                 ENTRY_W     = 40;
    localparam logic [ENTRY_W-1:0] RESET_ENTRY = {8'h00, 27'd0, FSEL_NULL};

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  bank;
        logic [1:0]  region;
        logic [1:0]  word_sel;
        logic [1:0]  alias_req;
        logic [4:0]  pin;
        logic [31:0] wdata;
        logic [31:0] pad_levels;
    } gbr_req_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic [31:0] pin_drive;
        logic [31:0] pin_enable;
        logic [2:0]  irq_lines;
    } gbr_rsp_t;

    // Decoded control bits that the drive and interrupt logic need for every pin.
    typedef struct packed {
        logic       gpio;
        logic [1:0] oov;
        logic [1:0] eov;
        logic [1:0] iov;
        logic [3:0] msk;
    } gbr_pin_cfg_t;

    function automatic logic [31:0] alias_apply(input logic [31:0] old_val,
                                                input logic [31:0] data,
                                                input logic [1:0]  kind);
        logic [31:0] res;
        unique case (kind)
            ALIAS_PLAIN: res = data;
            ALIAS_XOR:   res = old_val ^ data;
            ALIAS_SET:   res = old_val | data;
            ALIAS_CLR:   res = old_val & ~data;
        endcase
        return res;
    endfunction

    function automatic logic override_bit(input logic v, input logic [1:0] code);
        logic res;
        unique case (code)
            OVR_PASS: res = v;
            OVR_INV:  res = ~v;
            OVR_LOW:  res = 1'b0;
            OVR_HIGH: res = 1'b1;
        endcase
        return res;
    endfunction

    function automatic gbr_pin_cfg_t ctl_decode(input logic [31:0] ctl);
        gbr_pin_cfg_t cfg;
        cfg.gpio = (ctl[4:0] == FSEL_GPIO);
        cfg.oov  = ctl[CTL_OOV_LSB +: 2];
        cfg.eov  = ctl[CTL_EOV_LSB +: 2];
        cfg.iov  = ctl[CTL_IOV_LSB +: 2];
        cfg.msk  = ctl[CTL_MSK_LSB +: 4];
        return cfg;
    endfunction

endpackage

`default_nettype wire

>>> sv/gbr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module gbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic                                 re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/gpio_bank_register_block.sv
// Top level of the GPIO bank register block: access pipeline, pin state and result register.
//
// Every transaction (register read, register write, pad sample or no-op of one bank)
// passes through the input register and the result register. On acceptance the input
// register is loaded and the pin's control and pad entry is read from the control memory.
// When it leaves the input register, the read-modify-write is done and the bank's drive,
// enable and interrupt outputs are loaded into the result register. A new transaction is
// taken in every cycle while the result register drains; a result held by the receiver
// stalls the input side. The memory read-modify-write is forwarded between neighbors.
// The control memory needs no clearing pass: one valid flag per pin returns the reset
// value until the entry is first written.
`default_nettype none

module gpio_bank_register_block
    import gbr_pkg::*;
#(
    parameter int NUM_BANKS     = 3,
    parameter int PINS_PER_BANK = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire gbr_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output gbr_rsp_t      rsp
);

    localparam int DEPTH = NUM_BANKS * PINS_PER_BANK;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Pipeline registers.
    logic               s1_vld_reg;
    gbr_req_t           s1_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic               ent_vld_reg;
    logic               fwd_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic               rsp_vld_reg;
    gbr_rsp_t           rsp_reg;
    gbr_rsp_t           rsp_next;

    // Architectural state held in flops.
    logic [31:0]  out_word_reg [NUM_BANKS];
    logic [31:0]  oe_word_reg  [NUM_BANKS];
    logic [31:0]  in_word_reg  [NUM_BANKS];
    logic [31:0]  ien_reg      [NUM_BANKS];
    gbr_pin_cfg_t pcfg_reg     [NUM_BANKS][PINS_PER_BANK];
    logic [1:0]   edge_reg     [NUM_BANKS][PINS_PER_BANK];
    logic         ram_vld_reg  [DEPTH];

    logic [31:0]  out_word_next [NUM_BANKS];
    logic [31:0]  oe_word_next  [NUM_BANKS];
    logic [31:0]  in_word_next  [NUM_BANKS];
    logic [31:0]  ien_next      [NUM_BANKS];
    gbr_pin_cfg_t pcfg_next     [NUM_BANKS][PINS_PER_BANK];
    logic [1:0]   edge_next     [NUM_BANKS][PINS_PER_BANK];

    // Handshake and memory control.
    logic               req_fire;
    logic               s1_fire;
    logic               req_in_range;
    logic [AW-1:0]      req_addr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_we;

    // Stage one decode.
    logic               bank_ok;
    logic               pin_ok;
    logic [ENTRY_W-1:0] ent;
    logic [31:0]        ctl_old;
    logic [7:0]         pads_old;
    logic [31:0]        ctl_merged;
    logic [31:0]        ctl_new;
    logic [7:0]         pads_new;
    logic               ctl_wr;

    assign s1_fire   = s1_vld_reg && (!rsp_vld_reg || rsp_ready);
    assign req_ready = !s1_vld_reg || s1_fire;
    assign req_fire  = req_valid && req_ready;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    assign req_in_range = (int'(req.bank) < NUM_BANKS) && (int'(req.pin) < PINS_PER_BANK);
    assign req_addr     = req_in_range ? AW'(int'(req.bank) * PINS_PER_BANK + int'(req.pin))
                                       : '0;

    gbr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ctl_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (req_fire),
        .raddr (req_addr),
        .rdata (ram_rdata)
    );

    assign bank_ok  = int'(s1_reg.bank) < NUM_BANKS;
    assign pin_ok   = int'(s1_reg.pin) < PINS_PER_BANK;
    assign ent      = fwd_reg ? fwd_data_reg : (ent_vld_reg ? ram_rdata : RESET_ENTRY);
    assign ctl_old  = ent[31:0];
    assign pads_old = ent[ENTRY_W-1:32];
    assign pads_new = 8'(alias_apply({24'd0, pads_old}, s1_reg.wdata, s1_reg.alias_req));

    always_comb
    begin
        ctl_merged            = alias_apply(ctl_old, s1_reg.wdata, s1_reg.alias_req);
        ctl_new               = ctl_merged;
        ctl_new[CTL_IRQRESET] = 1'b0;
    end

    assign ram_we = s1_fire && (s1_reg.op == OP_WRITE) && bank_ok && pin_ok
                    && ((s1_reg.region == RGN_CTRL) || (s1_reg.region == RGN_PADS));
    assign ctl_wr = ram_we && (s1_reg.region == RGN_CTRL);
    assign ram_wdata = (s1_reg.region == RGN_CTRL) ? {pads_old, ctl_new}
                                                   : {pads_new, ctl_old};

    // Next state and the result of the transaction in stage one.
    always_comb
    begin
        logic                 sel;
        logic                 hit;
        logic                 v;
        logic                 lvl;
        logic                 ev;
        logic                 o;
        logic [NUM_BANKS-1:0] irq_all;
        logic [31:0]          rd;

        sel     = 1'b0;
        hit     = 1'b0;
        v       = 1'b0;
        lvl     = 1'b0;
        ev      = 1'b0;
        o       = 1'b0;
        rd      = '0;
        irq_all = '0;
        rsp_next.pin_drive  = '0;
        rsp_next.pin_enable = '0;

        for (int b = 0; b < NUM_BANKS; b++)
        begin
            out_word_next[b] = out_word_reg[b];
            oe_word_next[b]  = oe_word_reg[b];
            in_word_next[b]  = in_word_reg[b];
            ien_next[b]      = ien_reg[b];
            sel = bank_ok && (int'(s1_reg.bank) == b);

            if (sel && (s1_reg.op == OP_READ))
            begin
                unique case (s1_reg.region)
                    RGN_FASTIO:
                    begin
                        if (s1_reg.word_sel == WSEL_OUT)
                            rd = out_word_reg[b];
                        else if (s1_reg.word_sel == WSEL_OE)
                            rd = oe_word_reg[b];
                        else if (s1_reg.word_sel == WSEL_IN)
                            rd = in_word_reg[b];
                    end
                    RGN_CTRL:  rd = pin_ok ? ctl_old : '0;
                    RGN_PADS:  rd = pin_ok ? {24'd0, pads_old} : '0;
                    RGN_IRQEN: rd = ien_reg[b];
                endcase
            end

            if (s1_fire && sel && (s1_reg.op == OP_WRITE))
            begin
                if (s1_reg.region == RGN_FASTIO && s1_reg.word_sel == WSEL_OUT)
                    out_word_next[b] = alias_apply(out_word_reg[b], s1_reg.wdata,
                                                   s1_reg.alias_req);
                if (s1_reg.region == RGN_FASTIO && s1_reg.word_sel == WSEL_OE)
                    oe_word_next[b] = alias_apply(oe_word_reg[b], s1_reg.wdata,
                                                  s1_reg.alias_req);
                if (s1_reg.region == RGN_IRQEN)
                    ien_next[b] = alias_apply(ien_reg[b], s1_reg.wdata, s1_reg.alias_req);
            end

            if (s1_fire && sel && (s1_reg.op == OP_SAMPLE))
            begin
                in_word_next[b] = '0;
            end

            for (int p = 0; p < PINS_PER_BANK; p++)
            begin
                pcfg_next[b][p] = pcfg_reg[b][p];
                edge_next[b][p] = edge_reg[b][p];
                hit = sel && (int'(s1_reg.pin) == p);

                if (ctl_wr && hit)
                begin
                    pcfg_next[b][p] = ctl_decode(ctl_new);
                    // The self-clearing edge reset is tested on the word before it is dropped.
                    if (ctl_merged[CTL_IRQRESET])
                        edge_next[b][p] = 2'b00;
                end

                if (s1_fire && sel && (s1_reg.op == OP_SAMPLE))
                begin
                    v = override_bit(s1_reg.pad_levels[p], pcfg_reg[b][p].iov);
                    edge_next[b][p] = edge_reg[b][p]
                                      | {v & ~in_word_reg[b][p], ~v & in_word_reg[b][p]};
                    in_word_next[b][p] = v;
                end
            end

            // Outputs are formed from the state as it stands after this transaction.
            for (int p = 0; p < PINS_PER_BANK; p++)
            begin
                lvl = in_word_next[b][p];
                ev  = (edge_next[b][p][0] & pcfg_next[b][p].msk[0])
                    | (edge_next[b][p][1] & pcfg_next[b][p].msk[1])
                    | (~lvl & pcfg_next[b][p].msk[2])
                    | (lvl & pcfg_next[b][p].msk[3]);
                if (ev && ien_next[b][p])
                    irq_all[b] = 1'b1;
                if (sel)
                begin
                    o = pcfg_next[b][p].gpio & out_word_next[b][p];
                    rsp_next.pin_drive[p] = override_bit(o, pcfg_next[b][p].oov);
                    o = pcfg_next[b][p].gpio & oe_word_next[b][p];
                    rsp_next.pin_enable[p] = override_bit(o, pcfg_next[b][p].eov);
                end
            end
        end

        rsp_next.rdata     = rd;
        rsp_next.irq_lines = 3'(irq_all);
    end

    // Pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            rsp_vld_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            ent_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
                s1_vld_reg <= req_valid;
            if (s1_fire)
                rsp_vld_reg <= 1'b1;
            else if (rsp_ready)
                rsp_vld_reg <= 1'b0;
            if (req_fire)
            begin
                // A write in this cycle to the entry being read is not seen by the RAM read.
                fwd_reg     <= ram_we && (s1_addr_reg == req_addr);
                ent_vld_reg <= ram_vld_reg[req_addr];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_reg       <= req;
            s1_addr_reg  <= req_addr;
            fwd_data_reg <= ram_wdata;
        end
        if (s1_fire)
            rsp_reg <= rsp_next;
    end

    // Bank and pin state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                out_word_reg[b] <= '0;
                oe_word_reg[b]  <= '0;
                in_word_reg[b]  <= '0;
                ien_reg[b]      <= '0;
                for (int p = 0; p < PINS_PER_BANK; p++)
                begin
                    pcfg_reg[b][p] <= ctl_decode(RESET_ENTRY[31:0]);
                    edge_reg[b][p] <= 2'b00;
                end
            end
            for (int i = 0; i < DEPTH; i++)
                ram_vld_reg[i] <= 1'b0;
        end
        else
        begin
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                out_word_reg[b] <= out_word_next[b];
                oe_word_reg[b]  <= oe_word_next[b];
                in_word_reg[b]  <= in_word_next[b];
                ien_reg[b]      <= ien_next[b];
                for (int p = 0; p < PINS_PER_BANK; p++)
                begin
                    pcfg_reg[b][p] <= pcfg_next[b][p];
                    edge_reg[b][p] <= edge_next[b][p];
                end
            end
            if (ram_we)
                ram_vld_reg[s1_addr_reg] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> sv/gbr_checker.sv
// Port-level assertions for the GPIO bank register block and the bind that attaches them.
`default_nettype none

module gbr_checker
    import gbr_pkg::*;
#(
    parameter int NUM_BANKS     = 3,
    parameter int PINS_PER_BANK = 32
) (
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     req_valid,
    input wire logic     req_ready,
    input wire gbr_req_t req,
    input wire logic     rsp_valid,
    input wire logic     rsp_ready,
    input wire gbr_rsp_t rsp
);

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

    // The input side only stalls when the result register is full and held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
    else $error("input stalled without output back-pressure");

    // An accepted transaction passes through the input register into the result register
    // unless the output blocks it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
    else $error("transaction result missing");

    // Nonexistent pins and banks never drive or interrupt.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.pin_drive >> PINS_PER_BANK) == 32'd0)
                      && ((rsp.pin_enable >> PINS_PER_BANK) == 32'd0)
                      && ((rsp.irq_lines >> NUM_BANKS) == 3'd0))
    else $error("output bit set for a pin or bank that does not exist");

endmodule

bind gpio_bank_register_block gbr_checker #(
    .NUM_BANKS     (NUM_BANKS),
    .PINS_PER_BANK (PINS_PER_BANK)
) u_gbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

>>> tb/sv/gpio_bank_register_block_tb.sv
// Self-checking testbench for the GPIO bank register block with a shadow-register scoreboard.
`timescale 1ns / 1ps

module gpio_bank_register_block_tb
    import gbr_pkg::*;
();

    localparam int NB          = 3;
    localparam int PPB         = 32;
    localparam int ITEM_TARGET = 1500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 10;

    // Codes that the block must ignore.
    localparam logic [1:0] WSEL_NONE   = 2'd3;
    localparam logic [1:0] BANK_ABSENT = 2'd3;

    class gpio_shadow;
        localparam int BANKS = 3;
        localparam int PINS  = 32;

        bit [31:0] out_w[BANKS];
        bit [31:0] oe_w[BANKS];
        bit [31:0] in_w[BANKS];
        bit [31:0] irq_en[BANKS];
        bit [31:0] ctl[BANKS*PINS];
        bit [7:0]  pad[BANKS*PINS];
        bit [1:0]  edges[BANKS*PINS];
        gbr_rsp_t  pending[$];
        int        errors;

        function new();
            for (int b = 0; b < BANKS; b++) begin
                out_w[b]  = '0;
                oe_w[b]   = '0;
                in_w[b]   = '0;
                irq_en[b] = '0;
            end
            for (int i = 0; i < BANKS*PINS; i++) begin
                ctl[i]   = 32'(FSEL_NULL);
                pad[i]   = '0;
                edges[i] = '0;
            end
            errors = 0;
        endfunction

        function bit [31:0] merged_word(bit [31:0] old_v, bit [31:0] d, bit [1:0] kind);
            case (kind)
                ALIAS_XOR: return old_v ^ d;
                ALIAS_SET: return old_v | d;
                ALIAS_CLR: return old_v & ~d;
                default:   return d;
            endcase
        endfunction

        function bit forced_level(bit v, bit [1:0] code);
            case (code)
                OVR_INV:  return ~v;
                OVR_LOW:  return 1'b0;
                OVR_HIGH: return 1'b1;
                default:  return v;
            endcase
        endfunction

        // Applies one transaction to the shadow state and forms the response it causes.
        function gbr_rsp_t predict_response(gbr_req_t r);
            gbr_rsp_t  x;
            int        b;
            int        idx;
            bit        wr;
            bit        v;
            bit        o;
            bit        lvl;
            bit        ev;
            bit [31:0] nv;
            bit [31:0] c;
            x   = '0;
            b   = int'(r.bank);
            wr  = (r.op == OP_WRITE);
            idx = b * PINS + int'(r.pin);
            if (b < BANKS && (r.op == OP_READ || r.op == OP_WRITE)) begin
                case (r.region)
                    RGN_FASTIO:
                        if (r.word_sel == WSEL_OUT) begin
                            if (wr) out_w[b] = merged_word(out_w[b], r.wdata, r.alias_req);
                            else x.rdata = out_w[b];
                        end else if (r.word_sel == WSEL_OE) begin
                            if (wr) oe_w[b] = merged_word(oe_w[b], r.wdata, r.alias_req);
                            else x.rdata = oe_w[b];
                        end else if (r.word_sel == WSEL_IN && !wr) begin
                            x.rdata = in_w[b];
                        end
                    RGN_CTRL:
                        if (wr) begin
                            nv = merged_word(ctl[idx], r.wdata, r.alias_req);
                            // The edge reset bit clears the latch and never stays set.
                            if (nv[CTL_IRQRESET]) begin
                                edges[idx]       = '0;
                                nv[CTL_IRQRESET] = 1'b0;
                            end
                            ctl[idx] = nv;
                        end else begin
                            x.rdata = ctl[idx];
                        end
                    RGN_PADS:
                        if (wr) pad[idx] = 8'(merged_word({24'd0, pad[idx]}, r.wdata,
                                                          r.alias_req));
                        else x.rdata = {24'd0, pad[idx]};
                    default:
                        if (wr) irq_en[b] = merged_word(irq_en[b], r.wdata, r.alias_req);
                        else x.rdata = irq_en[b];
                endcase
            end else if (b < BANKS && r.op == OP_SAMPLE) begin
                nv = '0;
                for (int p = 0; p < PINS; p++) begin
                    v = forced_level(r.pad_levels[p], ctl[b*PINS+p][CTL_IOV_LSB +: 2]);
                    o = in_w[b][p];
                    if (v && !o) edges[b*PINS+p][1] = 1'b1;
                    if (!v && o) edges[b*PINS+p][0] = 1'b1;
                    nv[p] = v;
                end
                in_w[b] = nv;
            end
            if (b < BANKS) begin
                for (int p = 0; p < PINS; p++) begin
                    c = ctl[b*PINS+p];
                    v = (c[4:0] == FSEL_GPIO) ? out_w[b][p] : 1'b0;
                    o = (c[4:0] == FSEL_GPIO) ? oe_w[b][p] : 1'b0;
                    x.pin_drive[p]  = forced_level(v, c[CTL_OOV_LSB +: 2]);
                    x.pin_enable[p] = forced_level(o, c[CTL_EOV_LSB +: 2]);
                end
            end
            for (int bb = 0; bb < BANKS; bb++) begin
                for (int p = 0; p < PINS; p++) begin
                    c   = ctl[bb*PINS+p];
                    lvl = in_w[bb][p];
                    ev  = (edges[bb*PINS+p][0] && c[CTL_MSK_LSB])
                       || (edges[bb*PINS+p][1] && c[CTL_MSK_LSB+1])
                       || (!lvl && c[CTL_MSK_LSB+2])
                       || (lvl && c[CTL_MSK_LSB+3]);
                    if (ev && irq_en[bb][p]) x.irq_lines[bb] = 1'b1;
                end
            end
            return x;
        endfunction

        function void note_request(gbr_req_t r);
            pending.push_back(predict_response(r));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(gbr_rsp_t got);
            gbr_rsp_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected response transaction: expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("rdata", want.rdata, got.rdata);
            compare_field("pin_drive", want.pin_drive, got.pin_drive);
            compare_field("pin_enable", want.pin_enable, got.pin_enable);
            compare_field("irq_lines", 32'(want.irq_lines), 32'(got.irq_lines));
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    gbr_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    gbr_rsp_t rsp;

    gpio_shadow shadow;
    int         items_sent;
    int         burst_left;
    int         cycles;
    bit [31:0]  last_pads;
    logic       rsp_seen;
    gbr_rsp_t   rsp_held;

    gpio_bank_register_block #(
        .NUM_BANKS     (NB),
        .PINS_PER_BANK (PPB)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Handshakes are sampled at the falling edge, where every signal is settled, and take
    // effect at the next rising edge.
    always @(negedge clk)
    begin
        rsp_seen = rst_n && rsp_valid && rsp_ready;
        rsp_held = rsp;
    end

    always @(posedge clk)
    begin
        if (rsp_seen)
            shadow.check_response(rsp_held);
    end

    // The receiver alternates between segments of steady, random, sparse and long-stall
    // readiness.
    initial
    begin
        int seg_len;
        int style;
        int stall;
        rsp_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            seg_len = $urandom_range(5, 60);
            style   = $urandom_range(0, 3);
            stall   = $urandom_range(4, 30);
            for (int k = 0; k < seg_len; k++)
            begin
                case (style)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ((k % stall) == stall - 1);
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic gbr_req_t make_req(logic [1:0] op, logic [1:0] bank,
                                          logic [1:0] region, logic [1:0] wsel,
                                          logic [1:0] kind, logic [4:0] pin,
                                          logic [31:0] wdata, logic [31:0] pads);
        gbr_req_t r;
        r.op         = op;
        r.bank       = bank;
        r.region     = region;
        r.word_sel   = wsel;
        r.alias_req  = kind;
        r.pin        = pin;
        r.wdata      = wdata;
        r.pad_levels = pads;
        return r;
    endfunction

    // Control words that mostly select the GPIO function, with random overrides and masks.
    function automatic logic [31:0] control_pattern();
        logic [31:0] v;
        v      = $urandom;
        v[4:0] = ($urandom_range(0, 3) != 0) ? FSEL_GPIO : 5'($urandom);
        v[CTL_IRQRESET] = ($urandom_range(0, 7) == 0);
        return v;
    endfunction

    function automatic logic [31:0] next_pads();
        if ($urandom_range(0, 1) == 1)
            last_pads = $urandom;
        else
            last_pads = last_pads ^ (32'd1 << $urandom_range(0, 31));
        return last_pads;
    endfunction

    function automatic gbr_req_t random_req();
        gbr_req_t r;
        int       sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)      r.op = OP_READ;
        else if (sel < 68) r.op = OP_WRITE;
        else if (sel < 95) r.op = OP_SAMPLE;
        else               r.op = OP_NOP;
        r.bank       = ($urandom_range(0, 11) == 0) ? BANK_ABSENT : 2'($urandom_range(0, 2));
        r.region     = 2'($urandom);
        r.word_sel   = ($urandom_range(0, 9) == 0) ? WSEL_NONE : 2'($urandom_range(0, 2));
        r.alias_req  = 2'($urandom);
        r.pin        = 5'($urandom);
        r.wdata      = (r.region == RGN_CTRL && $urandom_range(0, 1) == 1) ?
                       control_pattern() : 32'($urandom);
        r.pad_levels = next_pads();
        return r;
    endfunction

    task automatic send_req(input gbr_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        req       <= r;
        req_valid <= 1'b1;
        do @(negedge clk); while (req_ready !== 1'b1);
        @(posedge clk);
        shadow.note_request(r);
        burst_left--;
        items_sent++;
    endtask

    // A typical driver sequence on one bank: configure pins, enable interrupts, drive
    // outputs, sample pads a few times, read back and clear an edge latch.
    task automatic bank_bringup();
        logic [1:0] b;
        logic [4:0] p;
        b = 2'($urandom_range(0, 2));
        repeat ($urandom_range(3, 8))
            send_req(make_req(OP_WRITE, b, RGN_CTRL, WSEL_OUT, ALIAS_PLAIN, 5'($urandom),
                              control_pattern(), 32'd0));
        send_req(make_req(OP_WRITE, b, RGN_IRQEN, WSEL_OUT, 2'($urandom), 5'd0,
                          32'($urandom), 32'd0));
        send_req(make_req(OP_WRITE, b, RGN_FASTIO, WSEL_OUT, 2'($urandom), 5'd0,
                          32'($urandom), 32'd0));
        send_req(make_req(OP_WRITE, b, RGN_FASTIO, WSEL_OE, 2'($urandom), 5'd0,
                          32'($urandom), 32'd0));
        repeat ($urandom_range(3, 10))
            send_req(make_req(OP_SAMPLE, b, RGN_FASTIO, WSEL_OUT, ALIAS_PLAIN, 5'd0,
                              32'd0, next_pads()));
        p = 5'($urandom);
        send_req(make_req(OP_READ, b, RGN_CTRL, WSEL_OUT, ALIAS_PLAIN, p, 32'd0, 32'd0));
        send_req(make_req(OP_READ, b, RGN_FASTIO, WSEL_IN, ALIAS_PLAIN, 5'd0, 32'd0, 32'd0));
        send_req(make_req(OP_WRITE, b, RGN_CTRL, WSEL_OUT, ALIAS_SET, p,
                          32'd1 << CTL_IRQRESET, 32'd0));
    endtask

    initial
    begin
        shadow     = new();
        items_sent = 0;
        burst_left = 0;
        cycles     = 0;
        last_pads  = '0;
        rsp_seen   = 1'b0;
        rsp_held   = '0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset values, every write kind, overrides, edges and ignored cases.
        send_req(make_req(OP_READ, 2'd0, RGN_CTRL, WSEL_OUT, ALIAS_PLAIN, 5'd0, 0, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_CTRL, WSEL_OUT, ALIAS_PLAIN, 5'd0,
                          32'h00F0_0005, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_CTRL, WSEL_OUT, ALIAS_PLAIN, 5'd1,
                          32'h0022_D005, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_CTRL, WSEL_OUT, ALIAS_PLAIN, 5'd2,
                          32'h0001_301F, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_IRQEN, WSEL_OUT, ALIAS_PLAIN, 5'd0,
                          32'hFFFF_FFFF, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_FASTIO, WSEL_OUT, ALIAS_PLAIN, 5'd0,
                          32'hFFFF_FFFF, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_FASTIO, WSEL_OE, ALIAS_XOR, 5'd0,
                          32'hAAAA_AAAA, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_FASTIO, WSEL_OUT, ALIAS_CLR, 5'd0,
                          32'hFFFF_0000, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_FASTIO, WSEL_OUT, ALIAS_SET, 5'd0,
                          32'h0001_0000, 0));
        send_req(make_req(OP_READ, 2'd0, RGN_FASTIO, WSEL_OUT, ALIAS_PLAIN, 5'd0, 0, 0));
        send_req(make_req(OP_READ, 2'd0, RGN_FASTIO, WSEL_OE, ALIAS_PLAIN, 5'd0, 0, 0));
        send_req(make_req(OP_SAMPLE, 2'd0, RGN_FASTIO, WSEL_OUT, ALIAS_PLAIN, 5'd0, 0,
                          32'hFFFF_FFFF));
        send_req(make_req(OP_SAMPLE, 2'd0, RGN_FASTIO, WSEL_OUT, ALIAS_PLAIN, 5'd0, 0, 0));
        send_req(make_req(OP_READ, 2'd0, RGN_FASTIO, WSEL_IN, ALIAS_PLAIN, 5'd0, 0, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_CTRL, WSEL_OUT, ALIAS_SET, 5'd0,
                          32'h1000_0000, 0));
        send_req(make_req(OP_READ, 2'd0, RGN_CTRL, WSEL_OUT, ALIAS_PLAIN, 5'd0, 0, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_FASTIO, WSEL_IN, ALIAS_PLAIN, 5'd0,
                          32'hFFFF_FFFF, 0));
        send_req(make_req(OP_WRITE, 2'd0, RGN_FASTIO, WSEL_NONE, ALIAS_PLAIN, 5'd0,
                          32'hFFFF_FFFF, 0));
        send_req(make_req(OP_READ, 2'd0, RGN_FASTIO, WSEL_NONE, ALIAS_PLAIN, 5'd0, 0, 0));
        send_req(make_req(OP_WRITE, 2'd1, RGN_PADS, WSEL_OUT, ALIAS_PLAIN, 5'd31,
                          32'h1234_56AB, 0));
        send_req(make_req(OP_WRITE, 2'd1, RGN_PADS, WSEL_OUT, ALIAS_XOR, 5'd31,
                          32'hFFFF_FFFF, 0));
        send_req(make_req(OP_READ, 2'd1, RGN_PADS, WSEL_OUT, ALIAS_PLAIN, 5'd31, 0, 0));
        send_req(make_req(OP_WRITE, BANK_ABSENT, RGN_FASTIO, WSEL_OUT, ALIAS_PLAIN, 5'd0,
                          32'hFFFF_FFFF, 0));
        send_req(make_req(OP_SAMPLE, BANK_ABSENT, RGN_FASTIO, WSEL_OUT, ALIAS_PLAIN, 5'd0,
                          0, 32'hFFFF_FFFF));
        send_req(make_req(OP_READ, BANK_ABSENT, RGN_CTRL, WSEL_OUT, ALIAS_PLAIN, 5'd0, 0, 0));
        send_req(make_req(OP_NOP, 2'd0, RGN_FASTIO, WSEL_OUT, ALIAS_PLAIN, 5'd0,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_req(make_req(OP_WRITE, 2'd0, RGN_IRQEN, WSEL_OUT, ALIAS_CLR, 5'd0,
                          32'hFFFF_FFFF, 0));

        // Random part: single transactions mixed with driver-like bring-up sequences.
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                bank_bringup();
            else
                send_req(random_req());
        end
        req_valid <= 1'b0;

        while (shadow.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (shadow.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
